// ===== design/stok_pkg.sv =====
// Shared types, constants and character/keyword helpers for the source tokenizer.
// No dependencies; the top, lexer and queue design files refer to this package by scoped names.
package stok_pkg;

   localparam int POS_WIDTH = 16;
   localparam int SPAN_WIDTH = 16;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int NUM_KW = 6;

   typedef logic [POS_WIDTH-1:0] pos_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_WS      = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_NUMBER  = 3'd4,
      MODE_WORD    = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_COMMENT = 3'd0,
      KIND_WS      = 3'd1,
      KIND_STRING  = 3'd2,
      KIND_PUNCT   = 3'd3,
      KIND_NUMBER  = 3'd4,
      KIND_IDENT   = 3'd5,
      KIND_KEYWORD = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [SPAN_WIDTH-1:0]  span_from;
      logic [SPAN_WIDTH-1:0]  span_to;
      logic                   last;
   } rsp_item_type;

   // results of one lexer step headed for the result queue
   typedef struct packed {
      logic [1:0]    cnt;
      rsp_item_type  item0;
      rsp_item_type  item1;
   } rsp_wr_type;

   typedef struct packed {
      logic [NUM_KW-1:0] cand;
      logic [2:0]        wlen;
   } word_type;

   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COLON     = 8'h3A;

   localparam logic [NUM_KW-1:0] CAND_ALL = {NUM_KW{1'b1}};

   // keyword spellings, padded with zeros to eight columns
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"F", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd4, 3'd6, 3'd3, 3'd4, 3'd5};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
   endfunction

   function automatic logic is_word_start(input logic [7:0] c);
      return (c == CH_UNDERSCORE) || ((c >= "A") && (c <= "Z")) ||
             ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_word_start(c) || is_digit(c);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
             (c == CH_RBRACE) || (c == CH_COLON);
   endfunction

   // add one byte to the open word: drop keywords that no longer match
   function automatic word_type word_step(input word_type w, input logic [7:0] c);
      word_type r;
      r = w;
      for (int k = 0; k < NUM_KW; k++) begin
         if ((w.wlen >= KW_LEN[k]) || (KW_TEXT[k][w.wlen] != c)) begin
            r.cand[k] = 1'b0;
         end
      end
      if (w.wlen != 3'd7) begin
         r.wlen = w.wlen + 3'd1;
      end
      return r;
   endfunction

   function automatic kind_type word_kind(input word_type w);
      kind_type r;
      r = KIND_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
         if (w.cand[k] && (w.wlen == KW_LEN[k])) begin
            r = KIND_KEYWORD;
         end
      end
      return r;
   endfunction

   function automatic logic [SPAN_WIDTH-1:0] to_span(input pos_type p);
      logic [31:0] w;
      w = 32'(p);
      return w[SPAN_WIDTH-1:0];
   endfunction

   function automatic rsp_item_type make_item(input kind_type k, input pos_type from,
                                              input pos_type upto);
      rsp_item_type r;
      r.kind      = k;
      r.span_from = to_span(from);
      r.span_to   = to_span(upto);
      r.last      = 1'b0;
      return r;
   endfunction

endpackage

// ===== design/stok_if.sv =====
// Valid/ready channel interfaces for the tokenizer's byte input and token output.
// Depends on nothing; widths follow the item fields.
interface stok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_source;

   modport source(output valid, output ch, output end_of_source, input ready);
   modport sink(input valid, input ch, input end_of_source, output ready);
endinterface

interface stok_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] span_from;
   logic [15:0] span_to;
   logic        last;

   modport source(output valid, output kind, output span_from, output span_to,
                  output last, input ready);
   modport sink(input valid, input kind, input span_from, input span_to,
                input last, output ready);
endinterface

// ===== design/source_tokenizer_top.sv =====
// Source tokenizer top level: input register, lexer step, result queue.
// An accepted byte waits in the input register until its results fit in the queue.
// Throughput: one item per cycle while the 4-entry queue holds two or fewer tokens; it drains
//   one per cycle while rsp is ready, so a two-result byte costs one extra output slot.
// Reset (synchronous, active high): lexer returns to idle at position 0, queue empties.
// Uses stok_pkg, stok_req_if/stok_rsp_if, stok_lexer and stok_rsp_fifo.
module source_tokenizer_top (
   input  logic         clock,
   input  logic         reset,
   stok_req_if.sink     req_bus,
   stok_rsp_if.source   rsp_bus
);

   // input register: holds one byte until the queue has room for its results
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_ch_ff;
   logic       stage_eos_ff;

   logic                   go;
   logic                   room2;
   logic                   not_empty;
   stok_pkg::rsp_wr_type   wr;
   stok_pkg::rsp_item_type head;

   // the lexer steps when the staged byte's (up to two) results are sure to fit
   assign go            = stage_valid_ff && room2;
   assign req_bus.ready = !stage_valid_ff || go;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_bus.ready) begin
         stage_valid_in = req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stage_ch_ff  <= req_bus.ch;
         stage_eos_ff <= req_bus.end_of_source;
      end
   end

   stok_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .ch    (stage_ch_ff),
      .eos   (stage_eos_ff),
      .wr    (wr)
   );

   stok_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .pop       (rsp_bus.ready),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2)
   );

   // result channel straight off the queue head
   assign rsp_bus.valid     = not_empty;
   assign rsp_bus.kind      = head.kind;
   assign rsp_bus.span_from = head.span_from;
   assign rsp_bus.span_to   = head.span_to;
   assign rsp_bus.last      = head.last;

endmodule

// ===== design/stok_lexer.sv =====
// Lexer state and combinational step: closes/opens tokens for one byte.
// Uses stok_pkg; produces up to two result items per step.
module stok_lexer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [7:0]           ch,
   input  logic                 eos,
   output stok_pkg::rsp_wr_type wr
);

   stok_pkg::mode_type mode_ff, mode_in;
   stok_pkg::pos_type  pos_ff, pos_in;
   stok_pkg::pos_type  tstart_ff, tstart_in;
   logic [7:0]         quote_ff, quote_in;
   logic [7:0]         prior_ff, prior_in;
   stok_pkg::word_type word_ff, word_in;

   stok_pkg::mode_type mode_a;
   stok_pkg::word_type word_a;
   stok_pkg::pos_type  pos_prev;
   logic               start;
   logic               v_close, v_punct, v_open;
   stok_pkg::rsp_item_type it_close, it_punct, it_open;
   stok_pkg::kind_type open_kind;

   always_comb begin
      pos_prev  = pos_ff - stok_pkg::pos_type'(1);
      start     = 1'b0;
      v_close   = 1'b0;
      v_punct   = 1'b0;
      v_open    = 1'b0;
      mode_a    = mode_ff;
      word_a    = word_ff;
      it_close  = stok_pkg::make_item(stok_pkg::KIND_COMMENT, tstart_ff, pos_prev);
      it_punct  = stok_pkg::make_item(stok_pkg::KIND_PUNCT, pos_ff, pos_ff);
      it_open   = it_punct;
      open_kind = stok_pkg::KIND_IDENT;
      quote_in  = quote_ff;
      tstart_in = tstart_ff;

      // close the open token if this byte cannot extend it
      case (mode_ff)
         stok_pkg::MODE_COMMENT: begin
            if (ch == stok_pkg::CH_NEWLINE) begin
               v_close = 1'b1;
               start   = 1'b1;
            end
         end
         stok_pkg::MODE_WS: begin
            if (!stok_pkg::is_ws(ch)) begin
               v_close = 1'b1;
               it_close.kind = stok_pkg::KIND_WS;
               start   = 1'b1;
            end
         end
         stok_pkg::MODE_STRING: begin
            if ((ch == quote_ff) && (prior_ff != stok_pkg::CH_BACKSLASH)) begin
               v_close  = 1'b1;
               it_close = stok_pkg::make_item(stok_pkg::KIND_STRING, tstart_ff, pos_ff);
               mode_a   = stok_pkg::MODE_IDLE;
            end
         end
         stok_pkg::MODE_NUMBER: begin
            if (!stok_pkg::is_digit(ch)) begin
               v_close = 1'b1;
               it_close.kind = stok_pkg::KIND_NUMBER;
               start   = 1'b1;
            end
         end
         stok_pkg::MODE_WORD: begin
            if (stok_pkg::is_word_char(ch)) begin
               word_a = stok_pkg::word_step(word_ff, ch);
            end else begin
               v_close = 1'b1;
               it_close.kind = stok_pkg::word_kind(word_ff);
               start   = 1'b1;
            end
         end
         default: begin
            start = 1'b1;
         end
      endcase

      // open a token on this byte
      if (start) begin
         mode_a    = stok_pkg::MODE_IDLE;
         tstart_in = pos_ff;
         if (ch == stok_pkg::CH_HASH) begin
            mode_a = stok_pkg::MODE_COMMENT;
         end else if (stok_pkg::is_ws(ch)) begin
            mode_a = stok_pkg::MODE_WS;
         end else if ((ch == stok_pkg::CH_SQUOTE) || (ch == stok_pkg::CH_DQUOTE)) begin
            mode_a   = stok_pkg::MODE_STRING;
            quote_in = ch;
         end else if (stok_pkg::is_punct(ch)) begin
            v_punct = 1'b1;
         end else if (stok_pkg::is_digit(ch)) begin
            mode_a = stok_pkg::MODE_NUMBER;
         end else if (stok_pkg::is_word_start(ch)) begin
            mode_a = stok_pkg::MODE_WORD;
            word_a = stok_pkg::word_step('{cand: stok_pkg::CAND_ALL, wlen: 3'd0}, ch);
         end
      end

      // end of source flushes the open token and returns to reset state
      case (mode_a)
         stok_pkg::MODE_COMMENT: open_kind = stok_pkg::KIND_COMMENT;
         stok_pkg::MODE_WS:      open_kind = stok_pkg::KIND_WS;
         stok_pkg::MODE_STRING:  open_kind = stok_pkg::KIND_STRING;
         stok_pkg::MODE_NUMBER:  open_kind = stok_pkg::KIND_NUMBER;
         default:                open_kind = stok_pkg::word_kind(word_a);
      endcase
      it_open = stok_pkg::make_item(open_kind, tstart_in, pos_ff);

      if (eos) begin
         v_open    = (mode_a != stok_pkg::MODE_IDLE);
         mode_in   = stok_pkg::MODE_IDLE;
         pos_in    = '0;
         tstart_in = '0;
         quote_in  = '0;
         prior_in  = '0;
         word_in   = '{cand: stok_pkg::CAND_ALL, wlen: 3'd0};
      end else begin
         mode_in  = mode_a;
         pos_in   = pos_ff + stok_pkg::pos_type'(1);
         prior_in = ch;
         word_in  = word_a;
      end

      // pack the valid results in order, flag the final one
      wr.cnt   = 2'(v_close) + 2'(v_punct) + 2'(v_open);
      wr.item0 = v_close ? it_close : (v_punct ? it_punct : it_open);
      wr.item1 = (v_close && v_punct) ? it_punct : it_open;
      if (!go) begin
         wr.cnt = 2'd0;
      end
      wr.item0.last = (wr.cnt == 2'd1);
      wr.item1.last = (wr.cnt == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stok_pkg::MODE_IDLE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         quote_ff  <= '0;
         prior_ff  <= '0;
         word_ff   <= '{cand: stok_pkg::CAND_ALL, wlen: 3'd0};
      end else if (go) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         quote_ff  <= quote_in;
         prior_ff  <= prior_in;
         word_ff   <= word_in;
      end
   end

   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      go && eos |=> (pos_ff == '0) && (mode_ff == stok_pkg::MODE_IDLE))
      else $error("position/mode not cleared after end of source");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      go && !eos |=> pos_ff == $past(pos_ff) + stok_pkg::pos_type'(1))
      else $error("position did not advance by one");

   a_last_order: assert property (@(posedge clock) disable iff (reset)
      (wr.cnt == 2'd2) |-> (wr.item1.last && !wr.item0.last))
      else $error("last flag misplaced on a two-result step");

endmodule

// ===== design/stok_rsp_fifo.sv =====
// Result queue: takes up to two items a cycle, delivers one a cycle while pop is high.
// Uses stok_pkg for the item type and depth.
module stok_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  stok_pkg::rsp_wr_type   wr,
   input  logic                   pop,
   output stok_pkg::rsp_item_type head,
   output logic                   not_empty,
   output logic                   room2
);

   stok_pkg::rsp_item_type         mem_ff [stok_pkg::RSP_DEPTH];
   logic [stok_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stok_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stok_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic [stok_pkg::RSP_PTR_W-1:0] wr_ptr_nx;
   logic                           do_pop;

   assign not_empty = (count_ff != '0);
   assign room2     = (count_ff <= stok_pkg::RSP_CNT_W'(stok_pkg::RSP_DEPTH - 2));
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign wr_ptr_nx = wr_ptr_ff + stok_pkg::RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + stok_pkg::RSP_PTR_W'(wr.cnt);
      rd_ptr_in = rd_ptr_ff + stok_pkg::RSP_PTR_W'(do_pop);
      count_in  = count_ff + stok_pkg::RSP_CNT_W'(wr.cnt) - stok_pkg::RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr.item0;
      end
      if (wr.cnt == 2'd2) begin
         mem_ff[wr_ptr_nx] <= wr.item1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr.cnt != 2'd0) |-> room2)
      else $error("result queue written without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stok_pkg::RSP_CNT_W'(stok_pkg::RSP_DEPTH))
      else $error("result queue count out of range");

endmodule

// ===== sim/tb_source_tokenizer_top.sv =====
// Self-checking bench for source_tokenizer_top: byte items in, token items out.
// Depends on stok_pkg and the stok_req_if/stok_rsp_if channel interfaces.
module tb_source_tokenizer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 8;
   localparam int RANDOM_ITEMS   = 580;
   localparam int QUIET_ITEMS    = 120;   // tail of the random part runs without idling
   localparam int LONG_HOLD      = 60;    // receiver hold-off for the backpressure test
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item moving on either side
   localparam int TAIL_CYCLES    = 8;

   logic clock = 1'b0;
   logic reset;

   stok_req_if req_bus ();
   stok_rsp_if rsp_bus ();

   source_tokenizer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Lexer prediction: a private copy of the tokenizer state, advanced once
   // per accepted byte. Tokens it closes go to pending_tokens in order.
   // ---------------------------------------------------------------------
   stok_pkg::mode_type     lex_mode;
   stok_pkg::pos_type      cur_pos;
   stok_pkg::pos_type      tok_from;
   byte unsigned           quote_ch;
   byte unsigned           prev_ch;
   byte unsigned           word_buf[$];     // open word, first eight bytes only
   stok_pkg::rsp_item_type step_out[$];     // tokens closed by the current byte
   stok_pkg::rsp_item_type pending_tokens[$];

   string        kw_words[6] = '{"if", "else", "return", "def", "True", "False"};
   byte unsigned punct_set[5] = '{stok_pkg::CH_LPAREN, stok_pkg::CH_RPAREN,
                                  stok_pkg::CH_LBRACE, stok_pkg::CH_RBRACE,
                                  stok_pkg::CH_COLON};
   byte unsigned ws_set[3] = '{stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_NEWLINE};

   int  error_count = 0;
   bit  no_idle = 1'b0;    // suppresses random gaps on both sides
   bit  rsp_hold = 1'b0;   // asks the receiver for one long hold-off

   function automatic bit digit_byte(input byte unsigned c);
      return c inside {[8'h30 : 8'h39]};
   endfunction

   function automatic bit ws_byte(input byte unsigned c);
      return c inside {stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_NEWLINE};
   endfunction

   function automatic bit word_head(input byte unsigned c);
      return c inside {[8'h41 : 8'h5A], [8'h61 : 8'h7A], stok_pkg::CH_UNDERSCORE};
   endfunction

   // a word is a keyword only when it spells one exactly; longer words never do
   function automatic stok_pkg::kind_type closed_word_kind();
      bit same;
      foreach (kw_words[k]) begin
         if (word_buf.size() == kw_words[k].len()) begin
            same = 1'b1;
            foreach (word_buf[i]) begin
               if (word_buf[i] != kw_words[k][i]) same = 1'b0;
            end
            if (same) return stok_pkg::KIND_KEYWORD;
         end
      end
      return stok_pkg::KIND_IDENT;
   endfunction

   function automatic void close_token(input stok_pkg::kind_type k,
                                       input stok_pkg::pos_type from_p,
                                       input stok_pkg::pos_type to_p);
      stok_pkg::rsp_item_type t;
      t.kind      = k;
      t.span_from = from_p[stok_pkg::SPAN_WIDTH-1:0];
      t.span_to   = to_p[stok_pkg::SPAN_WIDTH-1:0];
      t.last      = 1'b0;
      step_out.push_back(t);
   endfunction

   function automatic void lexer_clear();
      lex_mode = stok_pkg::MODE_IDLE;
      cur_pos  = '0;
      tok_from = '0;
      quote_ch = 8'h00;
      prev_ch  = 8'h00;
      word_buf.delete();
   endfunction

   function automatic void tokenize_byte(input byte unsigned c, input bit eos);
      stok_pkg::pos_type      prev_p;
      bit                     reopen;
      stok_pkg::rsp_item_type t;
      prev_p = cur_pos - 1'b1;   // wraps with the position
      reopen = 1'b0;
      step_out.delete();

      // does this byte close the open token?
      case (lex_mode)
         stok_pkg::MODE_COMMENT: begin
            if (c == stok_pkg::CH_NEWLINE) begin
               close_token(stok_pkg::KIND_COMMENT, tok_from, prev_p);
               reopen = 1'b1;
            end
         end
         stok_pkg::MODE_WS: begin
            if (!ws_byte(c)) begin
               close_token(stok_pkg::KIND_WS, tok_from, prev_p);
               reopen = 1'b1;
            end
         end
         stok_pkg::MODE_STRING: begin
            // only the single preceding byte counts as an escape
            if (c == quote_ch && prev_ch != stok_pkg::CH_BACKSLASH) begin
               close_token(stok_pkg::KIND_STRING, tok_from, cur_pos);
               lex_mode = stok_pkg::MODE_IDLE;
            end
         end
         stok_pkg::MODE_NUMBER: begin
            if (!digit_byte(c)) begin
               close_token(stok_pkg::KIND_NUMBER, tok_from, prev_p);
               reopen = 1'b1;
            end
         end
         stok_pkg::MODE_WORD: begin
            if (word_head(c) || digit_byte(c)) begin
               if (word_buf.size() < 8) word_buf.push_back(c);
            end else begin
               close_token(closed_word_kind(), tok_from, prev_p);
               reopen = 1'b1;
            end
         end
         default: reopen = 1'b1;
      endcase

      // the same byte may start the next token
      if (reopen) begin
         lex_mode = stok_pkg::MODE_IDLE;
         tok_from = cur_pos;
         if (c == stok_pkg::CH_HASH) begin
            lex_mode = stok_pkg::MODE_COMMENT;
         end else if (ws_byte(c)) begin
            lex_mode = stok_pkg::MODE_WS;
         end else if (c == stok_pkg::CH_SQUOTE || c == stok_pkg::CH_DQUOTE) begin
            lex_mode = stok_pkg::MODE_STRING;
            quote_ch = c;
         end else if (c inside {stok_pkg::CH_LPAREN, stok_pkg::CH_RPAREN, stok_pkg::CH_LBRACE,
                                stok_pkg::CH_RBRACE, stok_pkg::CH_COLON}) begin
            close_token(stok_pkg::KIND_PUNCT, cur_pos, cur_pos);
         end else if (digit_byte(c)) begin
            lex_mode = stok_pkg::MODE_NUMBER;
         end else if (word_head(c)) begin
            lex_mode = stok_pkg::MODE_WORD;
            word_buf.delete();
            word_buf.push_back(c);
         end
      end
      prev_ch = c;

      // end of source closes whatever is open here and starts over at zero
      if (eos) begin
         case (lex_mode)
            stok_pkg::MODE_COMMENT: close_token(stok_pkg::KIND_COMMENT, tok_from, cur_pos);
            stok_pkg::MODE_WS:      close_token(stok_pkg::KIND_WS, tok_from, cur_pos);
            stok_pkg::MODE_STRING:  close_token(stok_pkg::KIND_STRING, tok_from, cur_pos);
            stok_pkg::MODE_NUMBER:  close_token(stok_pkg::KIND_NUMBER, tok_from, cur_pos);
            stok_pkg::MODE_WORD:    close_token(closed_word_kind(), tok_from, cur_pos);
            default: ;
         endcase
         lexer_clear();
      end else begin
         cur_pos = cur_pos + 1'b1;
      end

      if (step_out.size() != 0) begin
         t = step_out.pop_back();
         t.last = 1'b1;
         step_out.push_back(t);
      end
      foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Sender: drives at the falling edge, sees acceptance at the rising edge.
   // valid stays high from one item to the next unless a gap is inserted.
   // ---------------------------------------------------------------------
   task automatic send_byte(input byte unsigned c, input bit eos);
      int gap;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.ch            <= c;
      req_bus.end_of_source <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tokenize_byte(c, eos);
   endtask

   task automatic send_text(input string s, input bit eos_at_end);
      foreach (s[i]) send_byte(s[i], eos_at_end && (i == s.len() - 1));
   endtask

   function automatic byte unsigned random_word_byte(input bit with_digits);
      int r;
      r = $urandom_range(0, with_digits ? 62 : 52);
      if (r < 26) return 8'h61 + 8'(r);
      if (r < 52) return 8'h41 + 8'(r - 26);
      if (r == 52) return stok_pkg::CH_UNDERSCORE;
      return 8'h30 + 8'(r - 53);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            rsp_hold = 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // each token item against the oldest prediction
   always @(posedge clock) begin : check_tokens
      stok_pkg::rsp_item_type exp_tok;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token kind=%0d span=%0d..%0d last=%0d", $time,
                     rsp_bus.kind, rsp_bus.span_from, rsp_bus.span_to, rsp_bus.last);
            error_count++;
         end else begin
            exp_tok = pending_tokens.pop_front();
            if (rsp_bus.kind !== exp_tok.kind || rsp_bus.span_from !== exp_tok.span_from ||
                rsp_bus.span_to !== exp_tok.span_to || rsp_bus.last !== exp_tok.last) begin
               $display("%0t: token mismatch: expected kind=%0d span=%0d..%0d last=%0d,",
                        $time, exp_tok.kind, exp_tok.span_from, exp_tok.span_to,
                        exp_tok.last);
               $display("   actual kind=%0d span=%0d..%0d last=%0d",
                        rsp_bus.kind, rsp_bus.span_from, rsp_bus.span_to, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long with nothing accepted on either channel
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // every token kind at least once; the last byte closes a punctuation token at end
   task automatic test_token_kinds();
      send_text("def f1(9):#x\n\t\"s\"}", 1'b1);
   endtask

   // skipped zero byte, escaped quote, 0xFF inside the string, double backslash still escapes, unterminated
   task automatic test_string_escapes();
      send_byte(8'h00, 1'b0);
      send_text("'\\'", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\\\\'", 1'b1);
   endtask

   // prefixes and extensions of keywords, and a word ended by end of source
   task automatic test_keyword_lengths();
      send_text("returns True Fals", 1'b1);
   endtask

   // one byte closing one token and opening-and-closing another
   task automatic test_two_results();
      send_text("7(", 1'b1);
      send_text("ab ", 1'b1);
      send_text("#z\n", 1'b1);
   endtask

   // receiver holds off while single-byte tokens pile up behind it
   task automatic test_backpressure();
      rsp_hold = 1'b1;
      send_text("(){}:(){}:a(b)c{d}7:", 1'b1);
   endtask

   // random sources: mostly token-shaped fragments, some raw byte noise
   task automatic test_random_sources();
      byte unsigned src[$];
      byte unsigned b;
      string        w;
      int           target;
      int           sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
         src.delete();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) src.push_back(8'($urandom_range(0, 255)));
         end else begin
            target = $urandom_range(1, 30);
            while (src.size() < target) begin
               case ($urandom_range(0, 8))
                  0: begin
                     w = kw_words[$urandom_range(0, 5)];
                     foreach (w[i]) src.push_back(w[i]);
                     if ($urandom_range(0, 2) == 0) src.push_back(random_word_byte(1'b1));
                  end
                  1: begin
                     src.push_back(random_word_byte(1'b0));
                     repeat ($urandom_range(0, 9)) src.push_back(random_word_byte(1'b1));
                  end
                  2: repeat ($urandom_range(1, 5)) src.push_back(8'h30 + 8'($urandom_range(0, 9)));
                  3: repeat ($urandom_range(1, 3)) src.push_back(ws_set[$urandom_range(0, 2)]);
                  4: begin
                     b = $urandom_range(0, 1) ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE;
                     src.push_back(b);
                     repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 4))
                           0: src.push_back(stok_pkg::CH_BACKSLASH);
                           1: src.push_back(stok_pkg::CH_SQUOTE);
                           2: src.push_back(stok_pkg::CH_DQUOTE);
                           3: src.push_back(random_word_byte(1'b1));
                           default: src.push_back(8'($urandom_range(0, 255)));
                        endcase
                     end
                     if ($urandom_range(0, 4) != 0) src.push_back(b);
                  end
                  5: begin
                     src.push_back(stok_pkg::CH_HASH);
                     repeat ($urandom_range(0, 8)) begin
                        do b = 8'($urandom_range(0, 255)); while (b == stok_pkg::CH_NEWLINE);
                        src.push_back(b);
                     end
                     if ($urandom_range(0, 3) != 0) src.push_back(stok_pkg::CH_NEWLINE);
                  end
                  6: src.push_back(punct_set[$urandom_range(0, 4)]);
                  7: src.push_back(8'($urandom_range(0, 255)));
                  default: src.push_back(stok_pkg::CH_SPACE);
               endcase
            end
         end
         foreach (src[i]) send_byte(src[i], i == src.size() - 1);
         sent += src.size();
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.ch            = 8'h00;
      req_bus.end_of_source = 1'b0;
      lexer_clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_token_kinds();
      test_string_escapes();
      test_keyword_lengths();
      test_two_results();
      test_backpressure();
      test_random_sources();

      // drain: every predicted token must come out, then a short quiet tail
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
